// ----- hw/rtl/oaar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package oaar_pkg;

  // Ring geometry. Positions on the ports are 12 bits, so the ring holds 4096 slots.
  localparam int BUF_LEN  = 4096;
  localparam int ADDR_W   = $clog2(BUF_LEN);
  localparam int POS_W    = 12;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 48;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 88;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_COMMIT,
    ST_SWEEP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic fetch;
    logic commit;
    logic sweep;
    logic sweep_emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/overlap_add_accumulation_ring_core.sv -----
// Sequence: an accumulate, read or unused-command request passes IDLE, FETCH (store
//   read) and COMMIT (result registered); a clear zeroes each slot in SWEEP,
//   registering its result with the last write.
// Throughput: a request is taken only in IDLE with the result slot free; each
//   accumulate or read does a RAM read-modify-write on the sample store.
// Reset: synchronous, active low. After reset a clearing pass zeroes the store
//   with in_tready held low; read position and frame count reset to zero.
`timescale 1ns / 1ps
`default_nettype none
module overlap_add_accumulation_ring_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [oaar_pkg::IN_W-1:0]   in_tdata,  // sample_in, caller_index, delay
  input  wire logic [1:0]                  in_tuser,  // command
  input  wire logic                        in_tlast,  // last_in
  // result channel
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [oaar_pkg::OUT_W-1:0]  out_tdata, // sample_out, write_position,
                                                      // next_index, frames_read
  output logic                             out_tlast  // last_out
);
  import oaar_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  cmd_t     in_cmd;

  assign in_cmd = cmd_t'(in_tuser);

  // sequencer: init sweep, fetch/commit per request, clear sweep
  oaar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_cmd),
    .in_tready (in_tready),
    .stat      (dstat),
    .cmd       (dcmd)
  );

  // store, position/count registers and result register
  oaar_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dcmd),
    .stat       (dstat),
    .in_cmd     (in_cmd),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // a request is only taken when its result has somewhere to go
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("request taken with result slot busy");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/oaar_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module oaar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/oaar_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module oaar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire oaar_pkg::cmd_t    in_cmd,
  output logic                   in_tready,
  input  wire oaar_pkg::dp_stat_t stat,
  output oaar_pkg::dp_cmd_t      cmd
);
  import oaar_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_cmd == CMD_CLEAR) ? ST_SWEEP : ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.sweep_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // a non-clear request passes fetch and then reaches commit after it is taken
  a_commit_two_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_cmd != CMD_CLEAR) |-> ##2 cmd.commit)
    else $error("commit not two cycles after accept");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/oaar_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module oaar_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire oaar_pkg::dp_cmd_t               cmd,
  output oaar_pkg::dp_stat_t                   stat,
  input  wire oaar_pkg::cmd_t                  in_cmd,
  input  wire logic [oaar_pkg::IN_W-1:0]       in_data,
  input  wire logic                            in_last,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [oaar_pkg::OUT_W-1:0]      out_tdata,
  output logic                                 out_tlast
);
  import oaar_pkg::*;

  // latched request
  cmd_t                       cmd_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [POS_W-1:0]           cidx_r;
  logic [POS_W-1:0]           dly_r;
  logic                       last_r;

  // ring state
  logic [ADDR_W-1:0]  rp_r, rp_nxt;
  logic [COUNT_W-1:0] fc_r, fc_nxt;
  logic [ADDR_W-1:0]  sweep_cnt_r;

  // result register
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  o_sample_r, o_sample_nxt;
  logic [POS_W-1:0]     o_wp_r, o_wp_nxt;
  logic [POS_W-1:0]     o_nidx_r, o_nidx_nxt;
  logic [COUNT_W-1:0]   o_fc_r;
  logic                 o_last_r;

  logic [POS_W:0]        wp_sum, nidx_sum;
  logic [ADDR_W-1:0]     wp, nidx, item_addr, ram_waddr;
  logic                  ram_we;
  logic [SAMPLE_W-1:0]   ram_wdata, ram_rdata;
  logic signed [SAMPLE_W:0] acc_sum;
  logic [SAMPLE_W-1:0]   acc_sat;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r    <= in_cmd;
      sample_r <= in_data[SAMPLE_W-1:0];
      cidx_r   <= in_data[SAMPLE_W +: POS_W];
      dly_r    <= in_data[SAMPLE_W+POS_W +: POS_W];
      last_r   <= in_last;
    end
  end

  // one compare-subtract: both sums stay below twice the ring length
  always_comb begin
    wp_sum   = {1'b0, cidx_r} + {1'b0, dly_r};
    nidx_sum = {1'b0, cidx_r} + (POS_W+1)'(1);
    wp   = (wp_sum >= (POS_W+1)'(BUF_LEN)) ? ADDR_W'(wp_sum - (POS_W+1)'(BUF_LEN))
                                           : ADDR_W'(wp_sum);
    nidx = (nidx_sum >= (POS_W+1)'(BUF_LEN)) ? ADDR_W'(nidx_sum - (POS_W+1)'(BUF_LEN))
                                             : ADDR_W'(nidx_sum);
    item_addr = (cmd_r == CMD_ACCUM) ? wp : rp_r;
  end

  // saturating Q1.15 add
  always_comb begin
    acc_sum = {ram_rdata[SAMPLE_W-1], ram_rdata} + {sample_r[SAMPLE_W-1], sample_r};
    if (acc_sum[SAMPLE_W] != acc_sum[SAMPLE_W-1]) begin
      acc_sat = acc_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = item_addr;
    ram_wdata    = '0;
    rp_nxt       = rp_r;
    fc_nxt       = fc_r;
    o_sample_nxt = '0;
    o_wp_nxt     = '0;
    o_nidx_nxt   = '0;
    if (cmd.sweep) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_r;
      if (cmd.sweep_emit) begin
        rp_nxt = '0;
        fc_nxt = '0;
      end
    end else if (cmd.commit) begin
      unique case (cmd_r)
        CMD_ACCUM: begin
          ram_we     = 1'b1;
          ram_wdata  = acc_sat;
          o_wp_nxt   = POS_W'(wp);
          o_nidx_nxt = POS_W'(nidx);
        end
        CMD_READ: begin
          ram_we       = 1'b1;
          o_sample_nxt = ram_rdata;
          rp_nxt       = (rp_r == ADDR_W'(BUF_LEN-1)) ? '0 : rp_r + ADDR_W'(1);
          fc_nxt       = fc_r + COUNT_W'(1);
        end
        CMD_CLEAR, CMD_RSVD: begin
        end
        default: begin
        end
      endcase
    end
  end

  oaar_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUF_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.fetch),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      fc_r        <= '0;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r <= rp_nxt;
      fc_r <= fc_nxt;
      if (cmd.sweep) begin
        sweep_cnt_r <= stat.sweep_last ? '0 : sweep_cnt_r + ADDR_W'(1);
      end
      if (cmd.commit || cmd.sweep_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.sweep_emit) begin
      o_sample_r <= o_sample_nxt;
      o_wp_r     <= o_wp_nxt;
      o_nidx_r   <= o_nidx_nxt;
      o_fc_r     <= fc_nxt;
      o_last_r   <= last_r;
    end
  end

  assign stat.sweep_last = (sweep_cnt_r == ADDR_W'(BUF_LEN-1));
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_fc_r, o_nidx_r, o_wp_r, o_sample_r};
  assign out_tlast  = o_last_r;

`ifndef ASSERT_OFF
  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.sweep_emit) |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");
  // frame counter moves only on a read commit or at the end of a clear
  a_fc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.commit && !cmd.sweep_emit) |=> $stable(fc_r))
    else $error("frame counter changed outside commit");
`endif

endmodule
`default_nettype wire
